// ----- src/hbdirq_pkg.sv -----
// Shared types and constants of the handheld bus decoder with IRQ timer.
// Used by the decoder and the top level; no dependencies.
package hbdirq_pkg;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_TICK  = 2'd2
  } mode_t;

  // Bank geometry and fixed video RAM size
  localparam int BANK_BITS  = 14;
  localparam int ROM_AW     = 17;
  localparam logic [ROM_AW-1:0] BANK_BYTES = 17'd16384;
  localparam int VRAM_DEPTH = 8192;
  localparam int VRAM_AW    = 13;

  // Configuration register reset: full 128 KiB cartridge
  localparam logic [17:0] ROM_BYTES_RESET = 18'd131072;

  // Bus map
  localparam logic [15:0] ADDR_WRAM_LAST  = 16'h1FFF;
  localparam logic [15:0] ADDR_LCD_FIRST  = 16'h2000;
  localparam logic [15:0] ADDR_LCD_LAST   = 16'h2007;
  localparam logic [15:0] ADDR_DMA_FIRST  = 16'h2008;
  localparam logic [15:0] ADDR_DMA_LAST   = 16'h200D;
  localparam logic [15:0] ADDR_SND_FIRST  = 16'h2010;
  localparam logic [15:0] ADDR_SND_LAST   = 16'h201C;
  localparam logic [15:0] ADDR_BUTTONS    = 16'h2020;
  localparam logic [15:0] ADDR_LINK_FIRST = 16'h2021;
  localparam logic [15:0] ADDR_LINK_LAST  = 16'h2022;
  localparam logic [15:0] ADDR_TIMER      = 16'h2023;
  localparam logic [15:0] ADDR_IRQ_ACK    = 16'h2024;
  localparam logic [15:0] ADDR_SND_ACK    = 16'h2025;
  localparam logic [15:0] ADDR_SYSCTL     = 16'h2026;
  localparam logic [15:0] ADDR_IRQ_ACK3   = 16'h2027;
  localparam logic [15:0] ADDR_SND2_FIRST = 16'h2028;
  localparam logic [15:0] ADDR_SND2_LAST  = 16'h202F;
  localparam logic [15:0] ADDR_VRAM       = 16'h4000;
  localparam logic [15:0] ADDR_ROM_BANKED = 16'h8000;
  localparam logic [15:0] ADDR_ROM_FIXED  = 16'hC000;

  // Read values of the fixed sources
  localparam logic [7:0] DATA_IRQ_ACK  = 8'd1;
  localparam logic [7:0] DATA_IRQ_ACK3 = 8'd3;
  localparam logic [7:0] DATA_UNMAPPED = 8'hFF;

  // System control bit positions
  localparam int SYSCTL_NMI  = 0;
  localparam int SYSCTL_IRQ  = 1;
  localparam int SYSCTL_SLOW = 4;

  // LCD register reset values
  localparam logic [7:0] LCD_RESET [4] = '{8'd160, 8'd160, 8'd0, 8'd0};

  // Decoded access, already qualified by the item kind
  typedef struct packed {
    logic rd_wram;
    logic rd_vram;
    logic rd_lcd;
    logic rd_timer;
    logic rd_ack1;
    logic rd_ack3;
    logic rd_btn;
    logic rd_rom_fixed;
    logic rd_rom_banked;
    logic wr_wram;
    logic wr_vram;
    logic wr_lcd;
    logic wr_timer;
    logic wr_sysctl;
    logic tick;
    logic unmapped;
  } dec_t;

endpackage

// ----- src/handheld_bus_decoder_irq_timer.sv -----
// Top level of the handheld bus decoder with IRQ timer.
// Depends on hbdirq_pkg, hbdirq_decode and hbdirq_ram.

// One item (bus read, bus write or timer tick) is taken per clock while in_stall is low; its
// result passes two register stages: the first stage decodes the item, updates the
// registers and issues the read of work or video RAM, the second stage picks up the
// registered RAM read data. The rate is set by the single read port of each RAM.
// After reset both RAMs are cleared one entry per cycle over all 8192 addresses, during which
// in_stall stays high; the rom_bytes register can be written at any time through
// the cfg channel, which is always ready. ROM reads are not served here: rom_fetch
// and rom_address tell an outside memory which byte to return.
module handheld_bus_decoder_irq_timer #(
  parameter int RAM_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  buttons_pressed,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        rom_fetch,
  output logic [16:0] rom_address,
  output logic        irq_request,
  output logic        nmi_allowed,
  output logic        unmapped_access,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [17:0] cfg_data
);

  localparam int WRAM_AW = $clog2(RAM_BYTES);
  localparam int RAM_FOLDS = 8;

  // Architectural state
  logic [17:0] rom_bytes;
  logic [7:0]  lcd_regs [4];
  logic [7:0]  timer_count;
  logic        irq_on;
  logic        nmi_on;
  logic        slow_prescale;
  logic [5:0]  prescale_phase;
  logic [2:0]  rom_bank;

  logic [7:0]  lcd_regs_next [4];
  logic [7:0]  timer_count_next;
  logic        irq_on_next;
  logic        nmi_on_next;
  logic        slow_prescale_next;
  logic [5:0]  prescale_phase_next;
  logic [2:0]  rom_bank_next;

  // Clearing pass
  logic                       clearing;
  logic [hbdirq_pkg::VRAM_AW-1:0] clr_addr;

  // Pipeline stage 1
  logic        s1_valid;
  logic [7:0]  s1_rd;
  logic        s1_fetch;
  logic [16:0] s1_raddr;
  logic        s1_irq;
  logic        s1_nmi;
  logic        s1_unm;
  logic        s1_use_wram;
  logic        s1_use_vram;

  logic [7:0]  rd_next;
  logic        fetch_next;
  logic [16:0] raddr_next;
  logic        irq_next;

  // Handshake
  logic accept;
  logic out_advance;
  logic s1_advance;

  hbdirq_pkg::dec_t dec;

  // RAM ports
  logic [WRAM_AW-1:0]             wram_idx;
  logic [12:0]                    wram_fold;
  logic                           wram_we;
  logic [WRAM_AW-1:0]             wram_waddr;
  logic [7:0]                     ram_wdata;
  logic [7:0]                     wram_q;
  logic                           vram_we;
  logic [hbdirq_pkg::VRAM_AW-1:0] vram_waddr;
  logic [7:0]                     vram_q;

  logic [5:0]  phase_inc;

  hbdirq_decode u_decode (
    .mode    (mode),
    .address (address),
    .dec     (dec)
  );

  // Flow control
  assign out_advance = !out_valid || !out_stall;
  assign s1_advance  = s1_valid && out_advance;
  assign in_stall    = clearing || (s1_valid && !out_advance);
  assign accept      = in_valid && !in_stall;
  assign cfg_ready   = 1'b1;

  // Fold the work RAM address into RAM_BYTES: pick the largest multiple at or below it
  always_comb begin
    wram_fold = '0;
    for (int k = 1; k < RAM_FOLDS; k++) begin
      if (32'(address[12:0]) >= k * RAM_BYTES) begin
        wram_fold = 13'(k * RAM_BYTES);
      end
    end
    wram_idx = WRAM_AW'(address[12:0] - wram_fold);
  end

  // RAM write ports: the clearing pass owns them after reset
  always_comb begin
    if (clearing) begin
      wram_we    = 32'(clr_addr) < RAM_BYTES;
      wram_waddr = clr_addr[WRAM_AW-1:0];
      vram_we    = 1'b1;
      vram_waddr = clr_addr;
      ram_wdata  = '0;
    end else begin
      wram_we    = accept && dec.wr_wram;
      wram_waddr = wram_idx;
      vram_we    = accept && dec.wr_vram;
      vram_waddr = address[hbdirq_pkg::VRAM_AW-1:0];
      ram_wdata  = write_data;
    end
  end

  hbdirq_ram #(
    .WIDTH (8),
    .DEPTH (RAM_BYTES)
  ) u_work_ram (
    .clk   (clk),
    .we    (wram_we),
    .waddr (wram_waddr),
    .wdata (ram_wdata),
    .re    (accept && dec.rd_wram),
    .raddr (wram_idx),
    .rdata (wram_q)
  );

  hbdirq_ram #(
    .WIDTH (8),
    .DEPTH (hbdirq_pkg::VRAM_DEPTH)
  ) u_video_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (ram_wdata),
    .re    (accept && dec.rd_vram),
    .raddr (address[hbdirq_pkg::VRAM_AW-1:0]),
    .rdata (vram_q)
  );

  // Register effects and result fields of one item
  assign phase_inc = prescale_phase + 6'd1;

  always_comb begin
    lcd_regs_next       = lcd_regs;
    timer_count_next    = timer_count;
    irq_on_next         = irq_on;
    nmi_on_next         = nmi_on;
    slow_prescale_next  = slow_prescale;
    prescale_phase_next = prescale_phase;
    rom_bank_next       = rom_bank;
    rd_next             = '0;
    fetch_next          = 1'b0;
    raddr_next          = '0;
    irq_next            = 1'b0;

    // reads
    if (dec.rd_timer) begin
      rd_next = timer_count;
    end
    if (dec.rd_ack1) begin
      rd_next     = hbdirq_pkg::DATA_IRQ_ACK;
      irq_on_next = 1'b0;
    end
    if (dec.rd_ack3) begin
      rd_next     = hbdirq_pkg::DATA_IRQ_ACK3;
      irq_on_next = 1'b0;
    end
    if (dec.rd_lcd) begin
      rd_next = lcd_regs[address[1:0]];
    end
    if (dec.rd_btn) begin
      rd_next = ~buttons_pressed;
    end
    if (dec.rd_rom_fixed) begin
      fetch_next = 1'b1;
      raddr_next = rom_bytes[16:0] - hbdirq_pkg::BANK_BYTES
                   + {3'b000, address[hbdirq_pkg::BANK_BITS-1:0]};
    end
    if (dec.rd_rom_banked) begin
      fetch_next = 1'b1;
      raddr_next = {rom_bank, address[hbdirq_pkg::BANK_BITS-1:0]};
    end
    if (dec.unmapped && mode == hbdirq_pkg::MODE_READ) begin
      rd_next = hbdirq_pkg::DATA_UNMAPPED;
    end

    // writes
    if (dec.wr_lcd) begin
      lcd_regs_next[address[1:0]] = write_data;
    end
    if (dec.wr_timer) begin
      timer_count_next    = write_data;
      irq_next            = (write_data == 8'd0) && irq_on;
      prescale_phase_next = '0;
    end
    if (dec.wr_sysctl) begin
      rom_bank_next      = write_data[7:5];
      slow_prescale_next = write_data[hbdirq_pkg::SYSCTL_SLOW];
      irq_on_next        = write_data[hbdirq_pkg::SYSCTL_IRQ];
      nmi_on_next        = write_data[hbdirq_pkg::SYSCTL_NMI];
    end

    // timer tick: a pending IRQ wins over counting
    if (dec.tick) begin
      if (irq_on && timer_count == 8'd0) begin
        irq_on_next = 1'b0;
        irq_next    = 1'b1;
      end else if (!slow_prescale) begin
        if (timer_count != 8'd0) begin
          timer_count_next = timer_count - 8'd1;
        end
      end else begin
        prescale_phase_next = phase_inc;
        if (phase_inc == 6'd0 && timer_count != 8'd0) begin
          timer_count_next = timer_count - 8'd1;
        end
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bytes <= hbdirq_pkg::ROM_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rom_bytes <= cfg_data;
    end
  end

  // Clearing pass: sweep both RAMs once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) begin
        clearing <= 1'b0;
      end
    end
  end

  // Update state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        lcd_regs[i] <= hbdirq_pkg::LCD_RESET[i];
      end
      timer_count    <= '0;
      irq_on         <= 1'b1;
      nmi_on         <= 1'b1;
      slow_prescale  <= 1'b0;
      prescale_phase <= '0;
      rom_bank       <= '0;
    end else if (accept) begin
      lcd_regs       <= lcd_regs_next;
      timer_count    <= timer_count_next;
      irq_on         <= irq_on_next;
      nmi_on         <= nmi_on_next;
      slow_prescale  <= slow_prescale_next;
      prescale_phase <= prescale_phase_next;
      rom_bank       <= rom_bank_next;
    end
  end

  // Stage 1: hold the decoded result while the RAM read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd       <= rd_next;
      s1_fetch    <= fetch_next;
      s1_raddr    <= raddr_next;
      s1_irq      <= irq_next;
      s1_nmi      <= nmi_on_next;
      s1_unm      <= dec.unmapped;
      s1_use_wram <= dec.rd_wram;
      s1_use_vram <= dec.rd_vram;
    end
  end

  // Result register: merge in the RAM read data
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      if (s1_use_wram) begin
        read_data <= wram_q;
      end else if (s1_use_vram) begin
        read_data <= vram_q;
      end else begin
        read_data <= s1_rd;
      end
      rom_fetch       <= s1_fetch;
      rom_address     <= s1_raddr;
      irq_request     <= s1_irq;
      nmi_allowed     <= s1_nmi;
      unmapped_access <= s1_unm;
    end
  end

endmodule

// ----- src/hbdirq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hbdirq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port: data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/hbdirq_decode.sv -----
// Address decoder of the bus: maps one item to its target region.
// Depends on hbdirq_pkg.
module hbdirq_decode (
  input  logic [1:0]         mode,
  input  logic [15:0]        address,
  output hbdirq_pkg::dec_t   dec
);

  always_comb begin
    dec = '0;
    case (mode)
      hbdirq_pkg::MODE_READ: begin
        if (address <= hbdirq_pkg::ADDR_WRAM_LAST) begin
          dec.rd_wram = 1'b1;
        end else if (address == hbdirq_pkg::ADDR_TIMER) begin
          dec.rd_timer = 1'b1;
        end else if (address == hbdirq_pkg::ADDR_IRQ_ACK) begin
          dec.rd_ack1 = 1'b1;
        end else if (address == hbdirq_pkg::ADDR_SND_ACK) begin
          // sound acknowledge reads as zero
        end else if (address == hbdirq_pkg::ADDR_IRQ_ACK3) begin
          dec.rd_ack3 = 1'b1;
        end else if (address <= hbdirq_pkg::ADDR_LCD_LAST) begin
          dec.rd_lcd = 1'b1;
        end else if (address == hbdirq_pkg::ADDR_BUTTONS) begin
          dec.rd_btn = 1'b1;
        end else if (address >= hbdirq_pkg::ADDR_ROM_FIXED) begin
          dec.rd_rom_fixed = 1'b1;
        end else if (address >= hbdirq_pkg::ADDR_ROM_BANKED) begin
          dec.rd_rom_banked = 1'b1;
        end else if (address >= hbdirq_pkg::ADDR_VRAM) begin
          dec.rd_vram = 1'b1;
        end else begin
          dec.unmapped = 1'b1;
        end
      end
      hbdirq_pkg::MODE_WRITE: begin
        if (address <= hbdirq_pkg::ADDR_WRAM_LAST) begin
          dec.wr_wram = 1'b1;
        end else if (address <= hbdirq_pkg::ADDR_LCD_LAST) begin
          dec.wr_lcd = 1'b1;
        end else if (address inside {
            [hbdirq_pkg::ADDR_DMA_FIRST : hbdirq_pkg::ADDR_DMA_LAST],
            [hbdirq_pkg::ADDR_LINK_FIRST : hbdirq_pkg::ADDR_LINK_LAST],
            [hbdirq_pkg::ADDR_SND_FIRST : hbdirq_pkg::ADDR_SND_LAST],
            [hbdirq_pkg::ADDR_SND2_FIRST : hbdirq_pkg::ADDR_SND2_LAST]}) begin
          // DMA, link and sound: take the write, drop it
        end else if (address == hbdirq_pkg::ADDR_TIMER) begin
          dec.wr_timer = 1'b1;
        end else if (address == hbdirq_pkg::ADDR_SYSCTL) begin
          dec.wr_sysctl = 1'b1;
        end else if (address >= hbdirq_pkg::ADDR_ROM_BANKED) begin
          // ROM region: drop the write
        end else if (address >= hbdirq_pkg::ADDR_VRAM) begin
          dec.wr_vram = 1'b1;
        end else begin
          dec.unmapped = 1'b1;
        end
      end
      hbdirq_pkg::MODE_TICK: begin
        dec.tick = 1'b1;
      end
      default: begin
        // unknown item kind: no effect
      end
    endcase
  end

endmodule

// ----- src/hbdirq_checker.sv -----
// Port-level checks of the handheld bus decoder, bound to the top level.
// Depends on handheld_bus_decoder_irq_timer's ports only.
module hbdirq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  read_data,
  input logic        rom_fetch,
  input logic [16:0] rom_address,
  input logic        irq_request,
  input logic        unmapped_access
);

  // A stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(rom_address))
    else $error("stalled result changed");

  // Reset empties the result side and starts the RAM clearing pass
  a_reset_clear: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("block not held off after reset");

  // An unmapped access neither fetches ROM nor raises an IRQ
  a_unmapped_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && unmapped_access |-> !rom_fetch && !irq_request)
    else $error("unmapped access with side result");

  // The ROM address reads zero on every result that does not fetch ROM
  a_rom_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rom_fetch |-> rom_address == 17'd0)
    else $error("ROM address without fetch");

endmodule

bind handheld_bus_decoder_irq_timer hbdirq_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .read_data       (read_data),
  .rom_fetch       (rom_fetch),
  .rom_address     (rom_address),
  .irq_request     (irq_request),
  .unmapped_access (unmapped_access)
);

// ----- verif/hbdirq_tb_pkg.sv -----
// Bus map shadow for the handheld bus decoder bench: predicts every response
// and compares the DUT output against it. Depends on hbdirq_pkg.
package hbdirq_tb_pkg;
  import hbdirq_pkg::*;

  // Work RAM size of the DUT as instantiated (default parameter)
  localparam int WRAM_BYTES = 8192;
  // Mode code with no meaning: no state change expected
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Cap on printed mismatch lines; the count keeps going
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        rom_fetch;
    logic [16:0] rom_address;
    logic        irq_request;
    logic        nmi_allowed;
    logic        unmapped_access;
  } bus_response_t;

  class bus_map_shadow;
    logic [7:0]  wram [VRAM_DEPTH];
    logic [7:0]  vram [VRAM_DEPTH];
    logic [7:0]  lcd [4];
    logic [7:0]  timer_value;
    logic        irq_enable;
    logic        nmi_enable;
    logic        slow_div;
    logic [5:0]  div_phase;
    logic [2:0]  bank;
    logic [17:0] cart_bytes;
    bus_response_t responses [$];
    int errors;
    int seen;
    int n_read;
    int n_write;
    int n_tick;
    int n_irq;
    int n_fetch;
    int n_unmapped;
    int n_sizes;

    function new();
      for (int i = 0; i < VRAM_DEPTH; i++) begin
        wram[i] = 8'h00;
        vram[i] = 8'h00;
      end
      for (int i = 0; i < 4; i++) lcd[i] = LCD_RESET[i];
      timer_value = 8'h00;
      irq_enable = 1'b1;
      nmi_enable = 1'b1;
      slow_div = 1'b0;
      div_phase = 6'd0;
      bank = 3'd0;
      cart_bytes = ROM_BYTES_RESET;
      errors = 0;
      seen = 0;
      n_read = 0;
      n_write = 0;
      n_tick = 0;
      n_irq = 0;
      n_fetch = 0;
      n_unmapped = 0;
      n_sizes = 0;
    endfunction

    function void set_cart_bytes(logic [17:0] v);
      cart_bytes = v;
      n_sizes++;
    endfunction

    function int pending();
      return responses.size();
    endfunction

    // Apply one accepted transfer to the shadow state and queue its response
    function void note_access(logic [1:0] m, logic [15:0] a, logic [7:0] wd, logic [7:0] btn);
      bus_response_t r;
      logic [31:0] sum;
      r = '0;
      case (m)
        MODE_READ: begin
          n_read++;
          if (a <= ADDR_WRAM_LAST) r.read_data = wram[a % WRAM_BYTES];
          else if (a == ADDR_TIMER) r.read_data = timer_value;
          else if (a == ADDR_IRQ_ACK) begin
            irq_enable = 1'b0;
            r.read_data = DATA_IRQ_ACK;
          end else if (a == ADDR_SND_ACK) r.read_data = 8'h00;
          else if (a == ADDR_IRQ_ACK3) begin
            irq_enable = 1'b0;
            r.read_data = DATA_IRQ_ACK3;
          end else if (a <= ADDR_LCD_LAST) r.read_data = lcd[a[1:0]];
          else if (a == ADDR_BUTTONS) r.read_data = ~btn;
          else if (a >= ADDR_ROM_FIXED) begin
            // fixed bank is the last 16 KiB of the cartridge, wrapped to 17 bits
            sum = 32'(cart_bytes) - 32'(BANK_BYTES) + 32'(a - ADDR_ROM_FIXED);
            r.rom_fetch = 1'b1;
            r.rom_address = sum[16:0];
          end else if (a >= ADDR_ROM_BANKED) begin
            sum = 32'(bank) * 32'(BANK_BYTES) + 32'(a - ADDR_ROM_BANKED);
            r.rom_fetch = 1'b1;
            r.rom_address = sum[16:0];
          end else if (a >= ADDR_VRAM) r.read_data = vram[a[12:0]];
          else begin
            r.read_data = DATA_UNMAPPED;
            r.unmapped_access = 1'b1;
          end
        end
        MODE_WRITE: begin
          n_write++;
          if (a <= ADDR_WRAM_LAST) wram[a % WRAM_BYTES] = wd;
          else if (a <= ADDR_LCD_LAST) lcd[a[1:0]] = wd;
          else if ((a >= ADDR_DMA_FIRST && a <= ADDR_DMA_LAST) ||
                   (a >= ADDR_LINK_FIRST && a <= ADDR_LINK_LAST) ||
                   (a >= ADDR_SND_FIRST && a <= ADDR_SND_LAST) ||
                   (a >= ADDR_SND2_FIRST && a <= ADDR_SND2_LAST)) begin
            // DMA, link and sound: accepted, no effect
          end else if (a == ADDR_TIMER) begin
            timer_value = wd;
            if (wd == 8'h00 && irq_enable) r.irq_request = 1'b1;
            div_phase = 6'd0;
          end else if (a == ADDR_SYSCTL) begin
            bank = wd[7:5];
            nmi_enable = wd[SYSCTL_NMI];
            irq_enable = wd[SYSCTL_IRQ];
            slow_div = wd[SYSCTL_SLOW];
          end else if (a >= ADDR_ROM_BANKED) begin
            // ROM region: drop the write
          end else if (a >= ADDR_VRAM) vram[a[12:0]] = wd;
          else r.unmapped_access = 1'b1;
        end
        MODE_TICK: begin
          n_tick++;
          if (irq_enable && timer_value == 8'h00) begin
            irq_enable = 1'b0;
            r.irq_request = 1'b1;
          end else if (!slow_div) begin
            if (timer_value != 8'h00) timer_value--;
          end else begin
            div_phase++;
            if (div_phase == 6'd0 && timer_value != 8'h00) timer_value--;
          end
        end
        default: ;
      endcase
      r.nmi_allowed = nmi_enable;
      if (r.irq_request) n_irq++;
      if (r.rom_fetch) n_fetch++;
      if (r.unmapped_access) n_unmapped++;
      responses.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("MISMATCH: %s", msg);
    endtask

    // Compare one accepted result transfer with the oldest queued response
    task check_response(bus_response_t got);
      bus_response_t want;
      if (responses.size() == 0) begin
        report($sformatf("result %0d arrived with no access outstanding", seen));
        seen++;
        return;
      end
      want = responses.pop_front();
      if (got.read_data !== want.read_data)
        report($sformatf("result %0d read_data %h, want %h", seen, got.read_data,
                         want.read_data));
      if (got.rom_fetch !== want.rom_fetch)
        report($sformatf("result %0d rom_fetch %b, want %b", seen, got.rom_fetch,
                         want.rom_fetch));
      if (got.rom_address !== want.rom_address)
        report($sformatf("result %0d rom_address %h, want %h", seen, got.rom_address,
                         want.rom_address));
      if (got.irq_request !== want.irq_request)
        report($sformatf("result %0d irq_request %b, want %b", seen, got.irq_request,
                         want.irq_request));
      if (got.nmi_allowed !== want.nmi_allowed)
        report($sformatf("result %0d nmi_allowed %b, want %b", seen, got.nmi_allowed,
                         want.nmi_allowed));
      if (got.unmapped_access !== want.unmapped_access)
        report($sformatf("result %0d unmapped_access %b, want %b", seen,
                         got.unmapped_access, want.unmapped_access));
      seen++;
    endtask
  endclass

endpackage

// ----- verif/tb_top.sv -----
// Top of the handheld bus decoder bench: clock, reset, stimulus and idling.
// Depends on hbdirq_pkg, hbdirq_tb_pkg and the handheld_bus_decoder_irq_timer RTL.
module tb_top;
  import hbdirq_pkg::*;
  import hbdirq_tb_pkg::*;

  localparam int IDLE_PCT     = 6;
  localparam int STALL_LIMIT  = 50000;
  // Total input items over all phases
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASES       = 7;
  localparam int DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [7:0]  buttons_pressed;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  read_data;
  logic        rom_fetch;
  logic [16:0] rom_address;
  logic        irq_request;
  logic        nmi_allowed;
  logic        unmapped_access;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [17:0] cfg_data;

  bus_map_shadow shadow;
  bit calm;
  int quiet_cycles;
  int pushed;

  handheld_bus_decoder_irq_timer DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .address         (address),
    .write_data      (write_data),
    .buttons_pressed (buttons_pressed),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .read_data       (read_data),
    .rom_fetch       (rom_fetch),
    .rom_address     (rom_address),
    .irq_request     (irq_request),
    .nmi_allowed     (nmi_allowed),
    .unmapped_access (unmapped_access),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= take_break();
  end

  // Sample every transfer at the rising edge; watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        shadow.note_access(mode, address, write_data, buttons_pressed);
      if (out_valid && !out_stall)
        shadow.check_response(bus_response_t'({read_data, rom_fetch, rom_address,
                                                irq_request, nmi_allowed,
                                                unmapped_access}));
      if (cfg_valid && cfg_ready) shadow.set_cart_bytes(cfg_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("[handheld_bus_decoder_irq_timer] ERROR");
        $finish;
      end
    end
  end

  // Offer one item, with random gaps first, and hold it until it transfers
  task automatic push_item(input logic [1:0] m, input logic [15:0] a, input logic [7:0] wd,
                           input logic [7:0] btn);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    address <= a;
    write_data <= wd;
    buttons_pressed <= btn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pushed++;
    @(negedge clk);
  endtask

  task automatic write_cart_bytes(input logic [17:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait until every response is back, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_address();
    logic [15:0] a;
    case ($urandom_range(0, 6))
      // small work RAM window at both ends so reads hit earlier writes
      0: a = 16'($urandom_range(0, 15)) | ($urandom_range(0, 1) ? 16'h1FF0 : 16'h0000);
      1: a = 16'($urandom_range(0, 16'h1FFF));
      2: a = ADDR_LCD_FIRST + 16'($urandom_range(0, 16'h2F));
      // video RAM window, upper half aliases the lower
      3: a = {2'b01, 1'($urandom), 8'h00, 5'($urandom)};
      4: a = 16'($urandom_range(16'h8000, 16'hFFFF));
      5: a = 16'($urandom_range(16'h2030, 16'h3FFF));
      default: a = 16'($urandom);
    endcase
    return a;
  endfunction

  task automatic push_random();
    int pick;
    int n;
    logic [15:0] a;
    logic [7:0] wd;
    logic [1:0] m;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // enable the IRQ, load a short count and run it down
      push_item(MODE_WRITE, ADDR_SYSCTL,
                {3'($urandom), ($urandom_range(0, 3) == 0), 2'($urandom), 1'b1, 1'($urandom)},
                8'($urandom));
      push_item(MODE_WRITE, ADDR_TIMER, 8'($urandom_range(0, 4)), 8'($urandom));
      n = $urandom_range(1, 6);
      repeat (n) push_item(MODE_TICK, 16'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 20) begin
      push_item(MODE_TICK, 16'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 21) begin
      push_item(MODE_UNUSED, 16'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      m = $urandom_range(0, 1) ? MODE_READ : MODE_WRITE;
      a = pick_address();
      wd = 8'($urandom);
      if (m == MODE_WRITE && a == ADDR_TIMER && $urandom_range(0, 1)) wd = 8'($urandom_range(0, 3));
      push_item(m, a, wd, 8'($urandom));
    end
  endtask

  // Walk the map edges, the LCD, button, timer, system control and acknowledge registers and the timer corners
  task automatic run_directed();
    push_item(MODE_WRITE, 16'h0000, 8'hFF, 8'h00);
    push_item(MODE_READ, 16'h0000, 8'h00, 8'h00);
    push_item(MODE_WRITE, ADDR_WRAM_LAST, 8'h5A, 8'h00);
    push_item(MODE_READ, ADDR_WRAM_LAST, 8'h00, 8'h00);
    push_item(MODE_READ, ADDR_LCD_FIRST, 8'h00, 8'h00);
    push_item(MODE_WRITE, ADDR_LCD_LAST, 8'hA5, 8'h00);
    push_item(MODE_READ, 16'h2003, 8'h00, 8'h00);
    push_item(MODE_READ, ADDR_BUTTONS, 8'h00, 8'h00);
    push_item(MODE_READ, ADDR_BUTTONS, 8'h00, 8'hFF);
    // tick with IRQ pending at reset, then timer holding at zero
    push_item(MODE_TICK, 16'h0000, 8'h00, 8'h00);
    push_item(MODE_TICK, 16'hFFFF, 8'hFF, 8'hFF);
    push_item(MODE_WRITE, ADDR_SYSCTL, 8'hF3, 8'h00);
    push_item(MODE_WRITE, ADDR_TIMER, 8'h00, 8'h00);
    push_item(MODE_READ, ADDR_IRQ_ACK, 8'h00, 8'h00);
    push_item(MODE_WRITE, ADDR_TIMER, 8'h02, 8'h00);
    push_item(MODE_TICK, 16'h0000, 8'h00, 8'h00);
    push_item(MODE_READ, ADDR_TIMER, 8'h00, 8'h00);
    push_item(MODE_READ, ADDR_SND_ACK, 8'h00, 8'h00);
    push_item(MODE_READ, ADDR_IRQ_ACK3, 8'h00, 8'h00);
    push_item(MODE_READ, ADDR_ROM_BANKED, 8'h00, 8'h00);
    push_item(MODE_READ, 16'hBFFF, 8'h00, 8'h00);
    push_item(MODE_READ, ADDR_ROM_FIXED, 8'h00, 8'h00);
    push_item(MODE_READ, 16'hFFFF, 8'h00, 8'h00);
    push_item(MODE_WRITE, ADDR_ROM_BANKED, 8'h12, 8'h00);
    push_item(MODE_WRITE, ADDR_DMA_FIRST, 8'h34, 8'h00);
    push_item(MODE_WRITE, 16'h3000, 8'h56, 8'h00);
    push_item(MODE_READ, 16'h3000, 8'h00, 8'h00);
    push_item(MODE_WRITE, ADDR_VRAM, 8'h81, 8'h00);
    push_item(MODE_READ, 16'h6000, 8'h00, 8'h00);
    // fast prescaler with NMI and IRQ off: count down one and hold
    push_item(MODE_WRITE, ADDR_SYSCTL, 8'h00, 8'h00);
    push_item(MODE_WRITE, ADDR_TIMER, 8'h01, 8'h00);
    push_item(MODE_TICK, 16'h0000, 8'h00, 8'h00);
    push_item(MODE_TICK, 16'h0000, 8'h00, 8'h00);
    push_item(MODE_UNUSED, 16'hFFFF, 8'hFF, 8'hFF);
  endtask

  initial begin
    logic [17:0] size;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_READ;
    address = 16'h0000;
    write_data = 8'h00;
    buttons_pressed = 8'h00;
    cfg_valid = 1'b0;
    cfg_data = 18'd0;
    calm = 1'b0;
    shadow = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Run each ROM size as its own phase; the third runs with no idling at all
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: size = ROM_BYTES_RESET;
        1: size = 18'd16384;
        2: size = 18'd98304;
        3: size = 18'd8192;
        4: size = 18'h3FFFF;
        5: size = 18'($urandom_range(16384, 131072));
        default: size = 18'd65536;
      endcase
      write_cart_bytes(size);
      calm = (phase == 2);
      if (phase == 0) run_directed();
      while (pushed < ((phase + 1) * RANDOM_ITEMS) / PHASES) push_random();
      settle();
    end
    calm = 1'b0;

    if (shadow.pending() != 0)
      shadow.report($sformatf("%0d responses never arrived", shadow.pending()));
    $display("covered %0d reads, %0d writes, %0d ticks over %0d ROM sizes",
             shadow.n_read, shadow.n_write, shadow.n_tick, shadow.n_sizes);
    $display("saw %0d IRQs, %0d ROM fetches, %0d unmapped accesses, %0d mismatches",
             shadow.n_irq, shadow.n_fetch, shadow.n_unmapped, shadow.errors);
    if (shadow.errors == 0)
      $display("[handheld_bus_decoder_irq_timer] OK");
    else
      $display("[handheld_bus_decoder_irq_timer] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
src/hbdirq_pkg.sv
src/hbdirq_ram.sv
src/hbdirq_decode.sv
src/handheld_bus_decoder_irq_timer.sv
src/hbdirq_checker.sv
verif/hbdirq_tb_pkg.sv
verif/tb_top.sv
